### rtl/core/vnf_pkg.sv
// Shared constants, register codes and arithmetic helpers for the fBm value noise unit.
package vnf_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_OCTAVES_DEF = 8;
   localparam int COORD_FRAC_DEF  = 16;

   // Field and datapath widths
   localparam int COORD_W    = 32;
   localparam int OCT_W      = 4;
   localparam int PERS_W     = 17;
   localparam int LAC_W      = 16;
   localparam int FREQ_W     = 48;   // unsigned Q36.12
   localparam int AMP_W      = 17;   // unsigned Q1.16
   localparam int VAL_W      = 18;   // signed Q1.16 corner / blend values
   localparam int WEIGHT_W   = 17;   // smoothstep weight, Q0.16 up to 1.0
   localparam int PROD_W     = 35;   // value * amplitude
   localparam int QUO_W      = 16;
   localparam int OUT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;
   localparam logic [PERS_W-1:0] PERS_RESET = 17'd32768;
   localparam logic [LAC_W-1:0]  LAC_RESET  = 16'd8192;
   localparam logic [AMP_W-1:0]  ONE_Q16    = 17'd65536;
   localparam logic [FREQ_W-1:0] FREQ_ONE   = 48'd4096;
   localparam logic [OUT_W-1:0]  OUT_MAX    = 16'h7FFF;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OCTAVE_COUNT = 2'd0,
      REG_PERSISTENCE  = 2'd1,
      REG_LACUNARITY   = 2'd2
   } csr_reg_type;

   // Shift-add / xor integer hash
   function automatic logic [31:0] mix32(input logic [31:0] v);
      logic [31:0] w;
      w = v + (v << 10);
      w = w ^ (w >> 6);
      w = w + (w << 3);
      w = w ^ (w >> 11);
      w = w + (w << 15);
      return w;
   endfunction

   // round(h * 131072 / 65535) - 65536; the divide by 65535 folds into two compares
   function automatic logic signed [VAL_W-1:0] corner_value(input logic [15:0] h);
      logic [17:0] base;
      logic [17:0] s;
      logic [17:0] adj;
      base = {1'b0, h, 1'b0};
      s    = base + 18'd32767;
      adj  = 18'(s >= 18'd65535) + 18'(s >= 18'd131070);
      return $signed(base + adj - 18'd65536);
   endfunction

   // a + floor(((b - a) * s + 32768) / 65536)
   function automatic logic signed [VAL_W-1:0] blend(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b,
                                                      input logic [WEIGHT_W-1:0] s);
      logic signed [VAL_W:0] d;
      logic signed [36:0]    p;
      d = (VAL_W+1)'(b) - (VAL_W+1)'(a);
      p = 37'(d) * 37'($signed({1'b0, s})) + 37'sd32768;
      return VAL_W'(37'(a) + (p >>> 16));
   endfunction

endpackage

### rtl/core/vnf_octave.sv
// One octave lane: coordinate scaling, lattice hash, smoothstep blend and amplitude weight.
module vnf_octave #(
   parameter int COORD_FRAC_BITS = vnf_pkg::COORD_FRAC_DEF
) (
   input  logic                                     clock,
   input  logic signed [vnf_pkg::COORD_W-1:0]       coord_x,
   input  logic signed [vnf_pkg::COORD_W-1:0]       coord_y,
   input  logic        [vnf_pkg::FREQ_W-1:0]        freq,
   input  logic        [vnf_pkg::AMP_W-1:0]         amp,
   output logic signed [vnf_pkg::PROD_W-1:0]        weighted
);
   import vnf_pkg::*;

   localparam int FR_R = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
   localparam int FR_L = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;
   localparam logic [31:0] FMASK = (32'd1 << COORD_FRAC_BITS) - 32'd1;

   // Stage 1: coordinate times frequency, split in two partial products
   logic signed [56:0] mxl_ff, mxh_ff, myl_ff, myh_ff;
   always_ff @(posedge clock) begin
      mxl_ff <= coord_x * $signed({1'b0, freq[23:0]});
      mxh_ff <= coord_x * $signed({1'b0, freq[47:24]});
      myl_ff <= coord_y * $signed({1'b0, freq[23:0]});
      myh_ff <= coord_y * $signed({1'b0, freq[47:24]});
   end

   // Stage 2: combine partial products, keep bits 12..43 (wraps modulo 2^32)
   logic [63:0] full_x, full_y;
   logic [31:0] px_ff, py_ff;
   assign full_x = {{7{mxl_ff[56]}}, mxl_ff} + ({{7{mxh_ff[56]}}, mxh_ff} << 24);
   assign full_y = {{7{myl_ff[56]}}, myl_ff} + ({{7{myh_ff[56]}}, myh_ff} << 24);
   always_ff @(posedge clock) begin
      px_ff <= full_x[43:12];
      py_ff <= full_y[43:12];
   end

   // Stage 3: lattice indices, row hashes, fraction squares and 3 - 2t factors
   logic [31:0] x0, y0;
   logic [15:0] tx, ty;
   logic [31:0] x0_ff, x1_ff, my0_ff, my1_ff, t2x_ff, t2y_ff;
   logic [17:0] kx_ff, ky_ff;
   assign x0 = 32'($signed(px_ff) >>> COORD_FRAC_BITS);
   assign y0 = 32'($signed(py_ff) >>> COORD_FRAC_BITS);
   assign tx = 16'(((px_ff & FMASK) >> FR_R) << FR_L);
   assign ty = 16'(((py_ff & FMASK) >> FR_R) << FR_L);
   always_ff @(posedge clock) begin
      x0_ff  <= x0;
      x1_ff  <= x0 + 32'd1;
      my0_ff <= mix32(y0);
      my1_ff <= mix32(y0 + 32'd1);
      t2x_ff <= 32'(tx) * 32'(tx);
      t2y_ff <= 32'(ty) * 32'(ty);
      kx_ff  <= 18'd196608 - {1'b0, tx, 1'b0};
      ky_ff  <= 18'd196608 - {1'b0, ty, 1'b0};
   end

   // Stage 4: corner hashes and smoothstep weights
   logic [31:0] h00, h10, h01, h11;
   logic [15:0] h00_ff, h10_ff, h01_ff, h11_ff;
   logic [WEIGHT_W-1:0] sx_ff, sy_ff;
   assign h00 = mix32(x0_ff ^ my0_ff);
   assign h10 = mix32(x1_ff ^ my0_ff);
   assign h01 = mix32(x0_ff ^ my1_ff);
   assign h11 = mix32(x1_ff ^ my1_ff);
   always_ff @(posedge clock) begin
      h00_ff <= h00[15:0];
      h10_ff <= h10[15:0];
      h01_ff <= h01[15:0];
      h11_ff <= h11[15:0];
      sx_ff  <= WEIGHT_W'((51'(t2x_ff) * 51'(kx_ff) + 51'h80000000) >> 32);
      sy_ff  <= WEIGHT_W'((51'(t2y_ff) * 51'(ky_ff) + 51'h80000000) >> 32);
   end

   // Stage 5: corner values and horizontal blends
   logic signed [VAL_W-1:0] r0_ff, r1_ff;
   logic [WEIGHT_W-1:0]     sy_d_ff;
   always_ff @(posedge clock) begin
      r0_ff   <= blend(corner_value(h00_ff), corner_value(h10_ff), sx_ff);
      r1_ff   <= blend(corner_value(h01_ff), corner_value(h11_ff), sx_ff);
      sy_d_ff <= sy_ff;
   end

   // Stage 6: vertical blend
   logic signed [VAL_W-1:0] v_ff;
   always_ff @(posedge clock) begin
      v_ff <= blend(r0_ff, r1_ff, sy_d_ff);
   end

   // Stage 7: amplitude weight
   logic signed [PROD_W-1:0] weighted_ff;
   always_ff @(posedge clock) begin
      weighted_ff <= PROD_W'(v_ff * $signed({1'b0, amp}));
   end
   assign weighted = weighted_ff;

endmodule

### rtl/core/vnf_divide.sv
// Pipelined restoring divider, one quotient bit per stage, for the final normalization.
module vnf_divide #(
   parameter int NUM_W = 38,
   parameter int DEN_W = 21
) (
   input  logic                          clock,
   input  logic [NUM_W-1:0]              num,
   input  logic                          neg_in,
   input  logic [DEN_W-1:0]              den,
   output logic [vnf_pkg::QUO_W-1:0]     quo,
   output logic                          neg_out
);
   import vnf_pkg::*;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] q_ff   [QUO_W];
   logic             neg_ff [QUO_W];

   // Stage j decides quotient bit QUO_W-1-j
   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [NUM_W-1:0] rem_prev;
      logic [QUO_W-1:0] q_prev;
      logic             neg_prev;
      logic [NUM_W-1:0] dsh;
      logic             ge;
      if (j == 0) begin : g_first
         assign rem_prev = num;
         assign q_prev   = '0;
         assign neg_prev = neg_in;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign neg_prev = neg_ff[j-1];
      end
      assign dsh = NUM_W'(den) << (QUO_W - 1 - j);
      assign ge  = rem_prev >= dsh;
      always_ff @(posedge clock) begin
         rem_ff[j] <= ge ? rem_prev - dsh : rem_prev;
         q_ff[j]   <= {q_prev[QUO_W-2:0], ge};
         neg_ff[j] <= neg_prev;
      end
   end

   assign quo     = q_ff[QUO_W-1];
   assign neg_out = neg_ff[QUO_W-1];

endmodule

### rtl/core/value_noise_fbm_2d_unit.sv
// Top level of the fractal value noise unit: config, octave lanes, sum, divide, output queue.
//
//  channel | ports                                   | direction | payload
//  --------+-----------------------------------------+-----------+---------------------------
//  req     | req_valid req_ready                     | in        | req_coord_x req_coord_y
//  rsp     | rsp_valid rsp_ready                     | out       | rsp_noise_value
//  csr     | csr_valid csr_ready                     | in        | csr_index csr_wdata
//
//  One transaction per cycle while req_ready is high; the latency is set by the octave lanes,
//  the adder tree and the 16-stage divider. Octaves run as parallel lanes.
//  After reset and after each csr write, a sequencer builds the per-octave frequency and
//  amplitude tables, one entry per octave lane; req and csr are not ready during that time.
//  The datapath never stalls: results land in an output queue sized above the latency, and
//  besides the table build, req_ready drops only when in-flight transactions fill that queue.
module value_noise_fbm_2d_unit #(
   parameter int MAX_OCTAVES     = vnf_pkg::MAX_OCTAVES_DEF,
   parameter int COORD_FRAC_BITS = vnf_pkg::COORD_FRAC_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [vnf_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [vnf_pkg::COORD_W-1:0]    req_coord_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [vnf_pkg::OUT_W-1:0]      rsp_noise_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [vnf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [vnf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vnf_pkg::*;

   localparam int LEVELS     = $clog2(MAX_OCTAVES);
   localparam int LEAVES     = 2 ** LEVELS;
   localparam int LEVELS_N   = (LEVELS > 0) ? LEVELS : 1;
   localparam int TOT_W      = PROD_W + LEVELS;
   localparam int AMPSUM_W   = AMP_W + LEVELS;
   localparam int STEP_W     = $clog2(MAX_OCTAVES + 1);
   localparam int IDX_W      = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int LAT        = 25 + LEVELS;
   localparam int FIFO_DEPTH = 2 ** $clog2(LAT + 1);
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   // ------------------------------------------------------------------
   // Configuration registers and table sequencer
   // ------------------------------------------------------------------
   logic [OCT_W-1:0]    oct_ff;
   logic [PERS_W-1:0]   pers_ff;
   logic [LAC_W-1:0]    lac_ff;
   logic                busy_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [FREQ_W-1:0]   freq_cur_ff;
   logic [AMP_W-1:0]    amp_cur_ff;
   logic [AMPSUM_W-1:0] ampsum_ff;
   logic [FREQ_W-1:0]   freq_tab_ff [MAX_OCTAVES];
   logic [AMP_W-1:0]    amp_tab_ff  [MAX_OCTAVES];

   logic              csr_fire;
   logic [4:0]        n_eff;
   logic [PERS_W-1:0] pers_sat;
   logic              active;
   logic [AMP_W-1:0]  amp_use;
   logic [FREQ_W-1:0] freq_cur_in;
   logic [AMP_W-1:0]  amp_cur_in;

   assign csr_ready = !busy_ff;
   assign csr_fire  = csr_valid && csr_ready;

   // Octave count limited to 1..MAX_OCTAVES, persistence to 1.0
   always_comb begin
      if (oct_ff == '0) begin
         n_eff = 5'd1;
      end else if (5'(oct_ff) > 5'(MAX_OCTAVES)) begin
         n_eff = 5'(MAX_OCTAVES);
      end else begin
         n_eff = 5'(oct_ff);
      end
      pers_sat    = (pers_ff > ONE_Q16) ? ONE_Q16 : pers_ff;
      active      = 5'(step_ff) < n_eff;
      amp_use     = active ? amp_cur_ff : '0;
      freq_cur_in = FREQ_W'((64'(freq_cur_ff) * 64'(lac_ff)) >> 12);
      amp_cur_in  = AMP_W'((34'(amp_cur_ff) * 34'(pers_sat) + 34'd32768) >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff      <= OCT_RESET;
         pers_ff     <= PERS_RESET;
         lac_ff      <= LAC_RESET;
         busy_ff     <= 1'b1;
         step_ff     <= '0;
         freq_cur_ff <= FREQ_ONE;
         amp_cur_ff  <= ONE_Q16;
         ampsum_ff   <= '0;
      end else if (csr_fire) begin
         unique case (csr_index)
            REG_OCTAVE_COUNT: oct_ff  <= csr_wdata[OCT_W-1:0];
            REG_PERSISTENCE:  pers_ff <= csr_wdata[PERS_W-1:0];
            REG_LACUNARITY:   lac_ff  <= csr_wdata[LAC_W-1:0];
            default: ;
         endcase
         busy_ff     <= 1'b1;
         step_ff     <= '0;
         freq_cur_ff <= FREQ_ONE;
         amp_cur_ff  <= ONE_Q16;
         ampsum_ff   <= '0;
      end else if (busy_ff) begin
         step_ff     <= step_ff + STEP_W'(1);
         freq_cur_ff <= freq_cur_in;
         amp_cur_ff  <= amp_cur_in;
         ampsum_ff   <= ampsum_ff + AMPSUM_W'(amp_use);
         if (step_ff == STEP_W'(MAX_OCTAVES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Per-octave tables; octaves past the count get zero amplitude
   always_ff @(posedge clock) begin
      if (busy_ff && !csr_fire && !reset) begin
         freq_tab_ff[step_ff[IDX_W-1:0]] <= freq_cur_ff;
         amp_tab_ff[step_ff[IDX_W-1:0]]  <= amp_use;
      end
   end

   // ------------------------------------------------------------------
   // Input register and valid chain
   // ------------------------------------------------------------------
   logic [PTR_W:0]                cnt_ff;
   logic [LAT-1:0]                vld_ff;
   logic signed [COORD_W-1:0]     cx_ff, cy_ff;
   logic                          req_fire, rsp_fire;

   assign req_ready = !busy_ff && (cnt_ff != (PTR_W+1)'(FIFO_DEPTH));
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cx_ff <= req_coord_x;
         cy_ff <= req_coord_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], req_fire};
      end
   end

   // In-flight count covers the pipeline and the output queue
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + (PTR_W+1)'(req_fire) - (PTR_W+1)'(rsp_fire);
      end
   end

   // ------------------------------------------------------------------
   // Octave lanes
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] lane_prod [MAX_OCTAVES];

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
      vnf_octave #(
         .COORD_FRAC_BITS (COORD_FRAC_BITS)
      ) u_octave (
         .clock    (clock),
         .coord_x  (cx_ff),
         .coord_y  (cy_ff),
         .freq     (freq_tab_ff[i]),
         .amp      (amp_tab_ff[i]),
         .weighted (lane_prod[i])
      );
   end

   // ------------------------------------------------------------------
   // Registered adder tree over the lanes
   // ------------------------------------------------------------------
   logic signed [TOT_W-1:0] leaf    [LEAVES];
   logic signed [TOT_W-1:0] tree_ff [LEVELS_N][LEAVES];
   logic signed [TOT_W-1:0] total;

   always_comb begin
      for (int j = 0; j < LEAVES; j++) begin
         leaf[j] = (j < MAX_OCTAVES) ? TOT_W'(lane_prod[j]) : '0;
      end
   end

   if (LEVELS == 0) begin : g_no_tree
      assign total = leaf[0];
   end else begin : g_tree
      for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
         for (genvar j = 0; j < (LEAVES >> (l + 1)); j++) begin : g_node
            if (l == 0) begin : g_leaf
               always_ff @(posedge clock) begin
                  tree_ff[0][j] <= leaf[2*j] + leaf[2*j+1];
               end
            end else begin : g_inner
               always_ff @(posedge clock) begin
                  tree_ff[l][j] <= tree_ff[l-1][2*j] + tree_ff[l-1][2*j+1];
               end
            end
         end
      end
      assign total = tree_ff[LEVELS-1][0];
   end

   // ------------------------------------------------------------------
   // Magnitude plus half divisor, then divide by twice the amplitude sum
   // ------------------------------------------------------------------
   logic [TOT_W-1:0] num_ff;
   logic             neg_ff;
   logic [TOT_W-1:0] mag;

   assign mag = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
   always_ff @(posedge clock) begin
      num_ff <= mag + TOT_W'(ampsum_ff);
      neg_ff <= total[TOT_W-1];
   end

   logic [QUO_W-1:0] div_q;
   logic             div_neg;

   vnf_divide #(
      .NUM_W (TOT_W),
      .DEN_W (AMPSUM_W + 1)
   ) u_divide (
      .clock   (clock),
      .num     (num_ff),
      .neg_in  (neg_ff),
      .den     ({ampsum_ff, 1'b0}),
      .quo     (div_q),
      .neg_out (div_neg)
   );

   // Sign restore and saturation to Q1.15
   logic [OUT_W-1:0] res;
   always_comb begin
      if (div_neg) begin
         res = OUT_W'(-div_q);
      end else if (div_q > OUT_MAX) begin
         res = OUT_MAX;
      end else begin
         res = OUT_W'(div_q);
      end
   end

   // ------------------------------------------------------------------
   // Output queue
   // ------------------------------------------------------------------
   logic [OUT_W-1:0] fifo_ff [FIFO_DEPTH];
   logic [PTR_W:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   occupancy;
   logic             fifo_wr;

   assign fifo_wr   = vld_ff[LAT-1];
   assign occupancy = wr_ptr_ff - rd_ptr_ff;
   assign rsp_valid = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_noise_value = $signed(fifo_ff[rd_ptr_ff[PTR_W-1:0]]);

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_ff[wr_ptr_ff[PTR_W-1:0]] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (fifo_wr) begin
            wr_ptr_ff <= wr_ptr_ff + (PTR_W+1)'(1);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + (PTR_W+1)'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PTR_W+1)'(FIFO_DEPTH))
      else $error("in-flight count above queue depth");

   a_queue_within_flight: assert property (@(posedge clock) disable iff (reset)
      occupancy <= cnt_ff)
      else $error("queue holds more results than transactions in flight");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_wr |-> (occupancy < (PTR_W+1)'(FIFO_DEPTH)))
      else $error("result written into a full queue");

   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> (busy_ff && step_ff == '0))
      else $error("csr write did not restart table build");

endmodule

### tb/value_noise_fbm_2d_unit_test.sv
// Testbench for the fractal value noise unit: directed and random coordinates against a predictor.
module value_noise_fbm_2d_unit_test;
   import vnf_pkg::*;

   localparam int LATENCY   = 40;
   localparam int WDOG_MAX  = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_noise_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the configuration registers
   logic [3:0]  octaves_reg = 4'd4;
   logic [16:0] persist_reg = 17'd32768;
   logic [15:0] lacun_reg   = 16'd8192;

   logic signed [15:0] noise_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit rsp_stall_on = 1'b1;

   value_noise_fbm_2d_unit dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Hash used for the lattice corners
   function automatic logic [31:0] hash_word(logic [31:0] v);
      logic [31:0] w;
      w = v + (v << 10);
      w = w ^ (w >> 6);
      w = w + (w << 3);
      w = w ^ (w >> 11);
      w = w + (w << 15);
      return w;
   endfunction

   function automatic longint lattice_level(logic [31:0] cx, logic [31:0] cy);
      longint h;
      h = longint'(hash_word(cx ^ hash_word(cy)) & 32'hFFFF);
      return (h * 131072 + 32767) / 65535 - 65536;
   endfunction

   // a + floor((d*s + 32768) / 65536)
   function automatic longint lerp_q16(longint a, longint b, longint s);
      return a + (((b - a) * s + 32768) >>> 16);
   endfunction

   function automatic longint fade_q16(longint t);
      logic [127:0] p;
      p = 128'(t * t) * 128'(3 * 65536 - 2 * t) + (128'd1 << 31);
      return longint'(p >> 32);
   endfunction

   function automatic logic [31:0] scale_by_freq(logic [31:0] c, logic [47:0] freq);
      logic [63:0] cs;
      logic [63:0] prod;
      cs = {{32{c[31]}}, c};
      prod = cs * {16'd0, freq};
      return prod[43:12];
   endfunction

   function automatic longint octave_sample(logic [31:0] px, logic [31:0] py);
      logic [31:0] x0, y0;
      longint sx, sy, r0, r1;
      x0 = {{16{px[31]}}, px[31:16]};
      y0 = {{16{py[31]}}, py[31:16]};
      sx = fade_q16(longint'(px[15:0]));
      sy = fade_q16(longint'(py[15:0]));
      r0 = lerp_q16(lattice_level(x0, y0), lattice_level(x0 + 1, y0), sx);
      r1 = lerp_q16(lattice_level(x0, y0 + 1), lattice_level(x0 + 1, y0 + 1), sx);
      return lerp_q16(r0, r1, sy);
   endfunction

   function automatic logic signed [15:0] fbm_noise(logic [31:0] cx, logic [31:0] cy);
      int n;
      longint pers, amp, ampsum, total, mag, q;
      logic [47:0] freq;
      logic [63:0] fprod;
      n = (octaves_reg == 0) ? 1 : (octaves_reg > 8 ? 8 : int'(octaves_reg));
      pers = (persist_reg > 17'd65536) ? 65536 : longint'(persist_reg);
      freq = 48'd4096;
      amp = 65536;
      ampsum = 0;
      total = 0;
      for (int i = 0; i < n; i++) begin
         total += octave_sample(scale_by_freq(cx, freq), scale_by_freq(cy, freq)) * amp;
         ampsum += amp;
         amp = (amp * pers + 32768) >> 16;
         fprod = {16'd0, freq} * {48'd0, lacun_reg};
         freq = fprod[59:12];
      end
      mag = (total < 0) ? -total : total;
      q = (mag + ampsum) / (2 * ampsum);
      if (q > 32768) q = 32768;
      if (total < 0) q = -q;
      if (q > 32767) q = 32767;
      return 16'(q);
   endfunction

   // Result checker and receiver stalls
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (noise_queue.size() == 0) begin
            $error("noise_value: unexpected transaction, actual %0d", rsp_noise_value);
            errors++;
         end else begin
            want = noise_queue.pop_front();
            if (rsp_noise_value !== want) begin
               $error("noise_value: expected %0d actual %0d", want, rsp_noise_value);
               errors++;
            end
         end
      end
      if (!rsp_stall_on) rsp_ready <= 1'b1;
      else if ($urandom_range(9) < 2) rsp_ready <= 1'b0;
      else if ($urandom_range(49) == 0) rsp_ready <= 1'b0;
      else rsp_ready <= 1'b1;
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WDOG_MAX) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Idle gap after a transaction; valid stays high when the next one follows at once
   task automatic random_gap();
      int g;
      g = ($urandom_range(9) == 0) ? $urandom_range(30, 5) :
          ($urandom_range(2) == 0 ? $urandom_range(2, 1) : 0);
      if (g != 0) req_valid <= 1'b0;
      repeat (g) @(posedge clock);
   endtask

   // Send one coordinate and queue its expected noise value
   task automatic send_coord(logic [31:0] x, logic [31:0] y);
      req_valid   <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      noise_queue.push_back(fbm_noise(x, y));
      do @(posedge clock); while (!req_ready);
      random_gap();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (noise_queue.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_OCTAVE_COUNT: octaves_reg = value[3:0];
         REG_PERSISTENCE:  persist_reg = value;
         REG_LACUNARITY:   lacun_reg = value[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [3:0] oct, logic [16:0] pers, logic [15:0] lac);
      drain();
      write_reg(REG_OCTAVE_COUNT, 17'(oct));
      write_reg(REG_PERSISTENCE, pers);
      write_reg(REG_LACUNARITY, 17'(lac));
      csr_valid <= 1'b0;
   endtask

   task automatic random_coords(int count, int span);
      logic [31:0] x, y;
      for (int i = 0; i < count; i++) begin
         if (span == 0) begin
            x = $urandom();
            y = $urandom();
         end else begin
            x = 32'($signed($urandom_range(2 * span)) - span);
            y = 32'($signed($urandom_range(2 * span)) - span);
         end
         send_coord(x, y);
      end
   endtask

   // Coordinate extremes and lattice edges at reset settings
   task automatic test_directed_extremes();
      send_coord(32'h0000_0000, 32'h0000_0000);
      send_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_coord(32'h8000_0000, 32'h8000_0000);
      send_coord(32'hFFFF_FFFF, 32'h0000_0001);
      send_coord(32'h0000_FFFF, 32'hFFFF_0000);
      send_coord(32'h0000_8000, 32'h0001_8000);
      send_coord(32'h7FFF_0000, 32'h8000_FFFF);
      send_coord(32'hAAAA_AAAA, 32'h5555_5555);
   endtask

   // Special cases of the registers: zero and oversize octaves, persistence above one,
   // lacunarity zero and out of range (frequency wrap)
   task automatic test_register_corners();
      configure(4'd0, 17'd0, 16'd4096);
      send_coord(32'h0001_2345, 32'hFFFE_8000);
      send_coord(32'h7FFF_FFFF, 32'h8000_0000);
      configure(4'd15, 17'h1FFFF, 16'd0);
      send_coord(32'h0003_4000, 32'h0002_C000);
      configure(4'd8, 17'd65536, 16'hFFFF);
      send_coord(32'h1234_5678, 32'h9ABC_DEF0);
      send_coord(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      configure(4'd1, 17'd65536, 16'd4096);
      send_coord(32'h0000_0000, 32'h0001_0000);
      send_coord(32'h0005_0000, 32'h0009_0000);
      configure(4'd8, 17'd0, 16'd32768);
      send_coord(32'h0000_4000, 32'h0000_C000);
      send_coord(32'h8000_0000, 32'h7FFF_FFFF);
   endtask

   // Random sweeps over several settings, with a drain before each new setting and one more mid-stream
   task automatic test_random_settings();
      configure(4'd4, 17'd32768, 16'd8192);
      random_coords(300, 0);
      random_coords(150, 32'h0010_0000);
      drain();
      random_coords(100, 32'h0000_4000);
      configure(4'd8, 17'd65536, 16'd32768);
      random_coords(250, 0);
      configure(4'd1, 17'd0, 16'd4096);
      random_coords(250, 32'h0100_0000);
      for (int k = 0; k < 6; k++) begin
         configure(4'($urandom_range(15)), 17'($urandom_range(131071)),
                   16'($urandom_range(65535)));
         random_coords(150, ($urandom_range(1) == 0) ? 0 : 32'h0004_0000);
      end
   endtask

   // Back to back traffic with the receiver always ready; the following drain drops valid
   task automatic test_streaming();
      configure(4'd3, 17'd40000, 16'd12000);
      rsp_stall_on = 1'b0;
      for (int i = 0; i < 100; i++) begin
         req_valid   <= 1'b1;
         req_coord_x <= $urandom();
         req_coord_y <= $urandom();
         @(posedge clock);
         noise_queue.push_back(fbm_noise(req_coord_x, req_coord_y));
         while (!req_ready) @(posedge clock);
      end
      rsp_stall_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_register_corners();
      test_random_settings();
      test_streaming();
      drain();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### value_noise_fbm_2d_unit.f
rtl/core/vnf_pkg.sv
rtl/core/vnf_octave.sv
rtl/core/vnf_divide.sv
rtl/core/value_noise_fbm_2d_unit.sv
tb/value_noise_fbm_2d_unit_test.sv
